>>> rtl/smvp_pkg.sv
// ----------------------------------------------------------------------------
// smvp_pkg
// Shared codes and controller/datapath interface types of the sparse
// matrix-vector product unit.
// ----------------------------------------------------------------------------
package smvp_pkg;

    localparam int KIND_W    = 3;
    localparam int SLOT_W    = 12;
    localparam int VALUE_W   = 32;
    localparam int COL_W     = 10;
    localparam int PTR_W     = 12;
    localparam int ACC_W     = 48;
    localparam int ROWCNT_W  = 11;
    localparam int ENTCNT_W  = 13;
    localparam int MODE_W    = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 13;
    localparam int ROW_AW    = 17;
    localparam int ENT_AW    = 13;

    localparam logic [KIND_W-1:0] KIND_LOAD_ENTRY = 3'd0;
    localparam logic [KIND_W-1:0] KIND_LOAD_PTR   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_LOAD_X     = 3'd2;
    localparam logic [KIND_W-1:0] KIND_COMPUTE    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_READ_Y     = 3'd4;

    localparam logic [MODE_W-1:0] MODE_DIAG = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SYM  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_GEN  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRIES = 2'd2;

    localparam logic RES_STATUS = 1'b0;
    localparam logic RES_READ   = 1'b1;

    typedef enum logic [1:0] {
        B_X,
        B_XCOL,
        B_XI
    } t_bsel;

    typedef struct packed {
        logic              ent_we;
        logic              ptr_we;
        logic              x_we;
        logic              ent_re;
        logic [ENT_AW-1:0] ent_raddr;
        logic              ptr_re;
        logic [ROW_AW-1:0] ptr_raddr;
        logic              x_re;
        logic [ROW_AW-1:0] x_raddr;
        logic              y_re;
        logic [ROW_AW-1:0] y_raddr;
        logic              y_we;
        logic              y_clr;
        logic [ROW_AW-1:0] y_waddr;
        logic              lat_a;
        logic              lat_b;
        t_bsel             b_sel;
        logic              lat_xi;
        logic              mul;
        logic              prod;
        logic              err_clr;
        logic              err_set;
        logic [COL_W-1:0]  err_row;
        logic              slot_lat;
        logic              out_load;
        logic              out_kind;
    } t_cmd;

    typedef struct packed {
        logic [COL_W-1:0] q_col;
        logic [COL_W-1:0] r_col;
        logic             col_ok;
        logic [PTR_W-1:0] ptr_q;
    } t_sts;

endpackage

>>> rtl/smvp_ram.sv
// ----------------------------------------------------------------------------
// smvp_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module smvp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_q;

endmodule

>>> rtl/smvp_dp.sv
// ----------------------------------------------------------------------------
// smvp_dp
// Datapath: matrix, pointer and vector stores, multiplier, saturating
// accumulator, error record and result register.
// ----------------------------------------------------------------------------
module smvp_dp #(
    parameter int MAX_ROWS    = 1024,
    parameter int MAX_ENTRIES = 4096,
    parameter int FRAC_BITS   = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  smvp_pkg::t_cmd                        i_cmd,
    output smvp_pkg::t_sts                        o_sts,
    input  logic [smvp_pkg::SLOT_W-1:0]           i_slot,
    input  logic signed [smvp_pkg::VALUE_W-1:0]   i_value,
    input  logic [smvp_pkg::COL_W-1:0]            i_column,
    input  logic [smvp_pkg::PTR_W-1:0]            i_row_start,
    output logic                                  o_result_kind,
    output logic signed [smvp_pkg::VALUE_W-1:0]   o_out_value,
    output logic [smvp_pkg::COL_W-1:0]            o_out_row,
    output logic                                  o_diag_error,
    output logic [smvp_pkg::COL_W-1:0]            o_bad_row
);
    import smvp_pkg::*;

    localparam int RW = $clog2(MAX_ROWS);
    localparam int EW = $clog2(MAX_ENTRIES);
    localparam int EDW = VALUE_W + COL_W;
    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    function automatic logic signed [ACC_W-1:0] sat_prod(input logic signed [63:0] v);
        logic signed [63:0] s;
        begin
            s = v >>> FRAC_BITS;
            if (s > 64'(ACC_MAX)) begin
                sat_prod = ACC_MAX;
            end else if (s < 64'(ACC_MIN)) begin
                sat_prod = ACC_MIN;
            end else begin
                sat_prod = s[ACC_W-1:0];
            end
        end
    endfunction

    function automatic logic signed [ACC_W-1:0] sat_sum(input logic signed [ACC_W:0] v);
        begin
            if (v > (ACC_W+1)'(ACC_MAX)) begin
                sat_sum = ACC_MAX;
            end else if (v < (ACC_W+1)'(ACC_MIN)) begin
                sat_sum = ACC_MIN;
            end else begin
                sat_sum = v[ACC_W-1:0];
            end
        end
    endfunction

    function automatic logic signed [VALUE_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
        begin
            if (v > ACC_W'(32'sh7FFF_FFFF)) begin
                sat32 = 32'sh7FFF_FFFF;
            end else if (v < ACC_W'(32'sh8000_0000)) begin
                sat32 = 32'sh8000_0000;
            end else begin
                sat32 = v[VALUE_W-1:0];
            end
        end
    endfunction

    logic [31:0] w_slot32, w_ent_ra32, w_ptr_ra32, w_x_ra32, w_y_ra32, w_y_wa32;
    logic [EDW-1:0]     w_ent_q;
    logic [PTR_W-1:0]   w_ptr_q;
    logic [VALUE_W-1:0] w_x_q;
    logic [ACC_W-1:0]   w_y_q;
    logic [ACC_W-1:0]   w_y_wdata;
    logic signed [VALUE_W-1:0] w_q_val;
    logic [COL_W-1:0]   w_q_col;

    logic signed [VALUE_W-1:0] r_a, r_b, r_xi;
    logic [COL_W-1:0]          r_col;
    logic signed [63:0]        r_mul;
    logic signed [ACC_W-1:0]   r_prod;
    logic [SLOT_W-1:0]         r_slot;
    logic                      r_rdok;
    logic                      r_err;
    logic [COL_W-1:0]          r_bad;
    logic                      r_okind;
    logic signed [VALUE_W-1:0] r_oval;
    logic [COL_W-1:0]          r_orow;
    logic                      r_oerr;
    logic [COL_W-1:0]          r_obad;

    assign w_slot32   = 32'(i_slot);
    assign w_ent_ra32 = 32'(i_cmd.ent_raddr);
    assign w_ptr_ra32 = 32'(i_cmd.ptr_raddr);
    assign w_x_ra32   = 32'(i_cmd.x_raddr);
    assign w_y_ra32   = 32'(i_cmd.y_raddr);
    assign w_y_wa32   = 32'(i_cmd.y_waddr);

    assign w_q_val = w_ent_q[VALUE_W-1:0];
    assign w_q_col = w_ent_q[EDW-1:VALUE_W];

    assign w_y_wdata = i_cmd.y_clr ? '0
                     : sat_sum((ACC_W+1)'($signed(w_y_q)) + (ACC_W+1)'(r_prod));

    smvp_ram #(.WIDTH(EDW), .DEPTH(MAX_ENTRIES)) u_ent (
        .i_clk   (i_clk),
        .i_we    (i_cmd.ent_we),
        .i_waddr (w_slot32[EW-1:0]),
        .i_wdata ({i_column, i_value}),
        .i_re    (i_cmd.ent_re),
        .i_raddr (w_ent_ra32[EW-1:0]),
        .o_rdata (w_ent_q)
    );

    smvp_ram #(.WIDTH(PTR_W), .DEPTH(MAX_ROWS)) u_ptr (
        .i_clk   (i_clk),
        .i_we    (i_cmd.ptr_we),
        .i_waddr (w_slot32[RW-1:0]),
        .i_wdata (i_row_start),
        .i_re    (i_cmd.ptr_re),
        .i_raddr (w_ptr_ra32[RW-1:0]),
        .o_rdata (w_ptr_q)
    );

    smvp_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_ROWS)) u_x (
        .i_clk   (i_clk),
        .i_we    (i_cmd.x_we),
        .i_waddr (w_slot32[RW-1:0]),
        .i_wdata (i_value),
        .i_re    (i_cmd.x_re),
        .i_raddr (w_x_ra32[RW-1:0]),
        .o_rdata (w_x_q)
    );

    smvp_ram #(.WIDTH(ACC_W), .DEPTH(MAX_ROWS)) u_y (
        .i_clk   (i_clk),
        .i_we    (i_cmd.y_we),
        .i_waddr (w_y_wa32[RW-1:0]),
        .i_wdata (w_y_wdata),
        .i_re    (i_cmd.y_re),
        .i_raddr (w_y_ra32[RW-1:0]),
        .o_rdata (w_y_q)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.lat_a) begin
            r_a   <= w_q_val;
            r_col <= w_q_col;
        end
        if (i_cmd.lat_b) begin
            unique case (i_cmd.b_sel)
                B_X:     r_b <= w_x_q;
                B_XCOL:  r_b <= (32'(r_col) < MAX_ROWS) ? w_x_q : '0;
                default: r_b <= r_xi;
            endcase
        end
        if (i_cmd.lat_xi) begin
            r_xi <= w_x_q;
        end
        if (i_cmd.mul) begin
            r_mul <= 64'(r_a) * 64'(r_b);
        end
        if (i_cmd.prod) begin
            r_prod <= sat_prod(r_mul);
        end
        if (i_cmd.slot_lat) begin
            r_slot <= i_slot;
            r_rdok <= w_slot32 < MAX_ROWS;
        end
        if (i_cmd.out_load) begin
            r_okind <= i_cmd.out_kind;
            r_oval  <= (i_cmd.out_kind == RES_READ && r_rdok) ? sat32(w_y_q) : '0;
            r_orow  <= (i_cmd.out_kind == RES_READ) ? r_slot[COL_W-1:0] : '0;
            r_oerr  <= r_err;
            r_obad  <= r_bad;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_err <= 1'b0;
            r_bad <= '0;
        end else if (i_cmd.err_clr) begin
            r_err <= 1'b0;
            r_bad <= '0;
        end else if (i_cmd.err_set && !r_err) begin
            r_err <= 1'b1;
            r_bad <= i_cmd.err_row;
        end
    end

    assign o_sts.q_col  = w_q_col;
    assign o_sts.r_col  = r_col;
    assign o_sts.col_ok = 32'(r_col) < MAX_ROWS;
    assign o_sts.ptr_q  = w_ptr_q;

    assign o_result_kind = r_okind;
    assign o_out_value   = r_oval;
    assign o_out_row     = r_orow;
    assign o_diag_error  = r_oerr;
    assign o_bad_row     = r_obad;

endmodule

>>> rtl/smvp_ctrl.sv
// ----------------------------------------------------------------------------
// smvp_ctrl
// Controller: configuration registers, command decode and the sequencer
// that walks rows and entries during a compute.
// ----------------------------------------------------------------------------
module smvp_ctrl #(
    parameter int MAX_ROWS    = 1024,
    parameter int MAX_ENTRIES = 4096
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_acc,
    input  logic [smvp_pkg::KIND_W-1:0]        i_kind,
    input  logic [smvp_pkg::SLOT_W-1:0]        i_slot,
    input  logic                               i_cfg_valid,
    input  logic [smvp_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [smvp_pkg::CFG_DAT_W-1:0]     i_cfg_data,
    input  logic                               i_m_tready,
    output logic                               o_s_tready,
    output logic                               o_m_tvalid,
    output smvp_pkg::t_cmd                     o_cmd,
    input  smvp_pkg::t_sts                     i_sts
);
    import smvp_pkg::*;

    localparam int RW = $clog2(MAX_ROWS);

    typedef enum logic [4:0] {
        S_IDLE, S_CLR, S_START, S_D_CHK, S_D_NX,
        S_SR_R1, S_SR_P0, S_SR_P1, S_SR_X, S_SR_XL, S_SR_LOOP, S_SR_MIR,
        S_SR_NX, S_SR_DG, S_SR_DC, S_SR_NROW,
        S_G_P0, S_G_P1, S_G_P2, S_G_LOOP, S_G_NX, S_G_NROW,
        S_E_LAT, S_X_LAT, S_LAT_AX, S_MUL, S_PROD, S_WR, S_RES
    } t_state;

    t_state r_state, n_state, r_ret, n_ret;
    logic [MODE_W-1:0]   r_mode;
    logic [ROWCNT_W-1:0] r_rows;
    logic [ENTCNT_W-1:0] r_ents;
    logic [ROWCNT_W-1:0] r_i, n_i;
    logic [ENTCNT_W-1:0] r_j, n_j, r_end, n_end;
    logic [ROWCNT_W-1:0] r_t, n_t;
    logic [RW-1:0]       r_c, n_c;
    logic                r_rd, n_rd;
    logic                r_ovalid, n_ovalid;
    logic                r_init, n_init;
    logic [ROWCNT_W-1:0] w_n;
    logic [ENTCNT_W-1:0] w_e;
    logic [ROWCNT_W-1:0] w_i1;
    t_cmd                w_cmd;

    assign w_n  = (32'(r_rows) > MAX_ROWS) ? ROWCNT_W'(MAX_ROWS) : r_rows;
    assign w_e  = (32'(r_ents) > MAX_ENTRIES) ? ENTCNT_W'(MAX_ENTRIES) : r_ents;
    assign w_i1 = r_i + ROWCNT_W'(1);

    always_comb begin
        n_state  = r_state;
        n_ret    = r_ret;
        n_i      = r_i;
        n_j      = r_j;
        n_end    = r_end;
        n_t      = r_t;
        n_c      = r_c;
        n_rd     = r_rd;
        n_init   = r_init;
        n_ovalid = r_ovalid && !i_m_tready;
        w_cmd    = '0;
        w_cmd.b_sel = B_X;

        unique case (r_state)
            S_IDLE: begin
                if (i_acc) begin
                    case (i_kind)
                        KIND_LOAD_ENTRY: w_cmd.ent_we = 32'(i_slot) < MAX_ENTRIES;
                        KIND_LOAD_PTR:   w_cmd.ptr_we = 32'(i_slot) < MAX_ROWS;
                        KIND_LOAD_X:     w_cmd.x_we   = 32'(i_slot) < MAX_ROWS;
                        KIND_COMPUTE: begin
                            w_cmd.err_clr = 1'b1;
                            n_c           = '0;
                            n_state       = S_CLR;
                        end
                        KIND_READ_Y: begin
                            w_cmd.slot_lat = 1'b1;
                            w_cmd.y_re     = 1'b1;
                            w_cmd.y_raddr  = ROW_AW'(i_slot);
                            n_rd           = RES_READ;
                            n_state        = S_RES;
                        end
                        default: ;
                    endcase
                end
            end
            S_CLR: begin
                w_cmd.y_we    = 1'b1;
                w_cmd.y_clr   = 1'b1;
                w_cmd.y_waddr = ROW_AW'(r_c);
                if (r_c == RW'(MAX_ROWS - 1)) begin
                    n_init  = 1'b0;
                    n_state = r_init ? S_IDLE : S_START;
                end else begin
                    n_c = r_c + RW'(1);
                end
            end
            S_START: begin
                n_rd = RES_STATUS;
                n_i  = '0;
                if (w_n == '0) begin
                    n_state = S_RES;
                end else begin
                    case (r_mode)
                        MODE_DIAG: n_state = S_D_CHK;
                        MODE_SYM: begin
                            if (w_e != '0) begin
                                w_cmd.ent_re = 1'b1;
                                w_cmd.x_re   = 1'b1;
                                n_t          = '0;
                                n_ret        = S_SR_R1;
                                n_state      = S_LAT_AX;
                            end else begin
                                n_state = S_SR_R1;
                            end
                        end
                        MODE_GEN: n_state = S_G_P0;
                        default:  n_state = S_RES;
                    endcase
                end
            end
            S_D_CHK: begin
                if (ENTCNT_W'(r_i) < w_e) begin
                    w_cmd.ent_re    = 1'b1;
                    w_cmd.ent_raddr = ENT_AW'(r_i);
                    w_cmd.x_re      = 1'b1;
                    w_cmd.x_raddr   = ROW_AW'(r_i);
                    n_t             = r_i;
                    n_ret           = S_D_NX;
                    n_state         = S_LAT_AX;
                end else begin
                    n_state = S_RES;
                end
            end
            S_D_NX: begin
                if (w_i1 == w_n) begin
                    n_state = S_RES;
                end else begin
                    n_i     = w_i1;
                    n_state = S_D_CHK;
                end
            end
            S_SR_R1: begin
                n_i     = ROWCNT_W'(1);
                n_state = (w_n == ROWCNT_W'(1)) ? S_RES : S_SR_P0;
            end
            S_SR_P0: begin
                w_cmd.ptr_re    = 1'b1;
                w_cmd.ptr_raddr = ROW_AW'(r_i - ROWCNT_W'(1));
                n_state         = S_SR_P1;
            end
            S_SR_P1: begin
                n_j             = ENTCNT_W'(i_sts.ptr_q) + ENTCNT_W'(1);
                w_cmd.ptr_re    = 1'b1;
                w_cmd.ptr_raddr = ROW_AW'(r_i);
                n_state         = S_SR_X;
            end
            S_SR_X: begin
                n_end         = ENTCNT_W'(i_sts.ptr_q);
                w_cmd.x_re    = 1'b1;
                w_cmd.x_raddr = ROW_AW'(r_i);
                n_state       = S_SR_XL;
            end
            S_SR_XL: begin
                w_cmd.lat_xi = 1'b1;
                n_state      = S_SR_LOOP;
            end
            S_SR_LOOP: begin
                if (r_j < r_end && r_j < w_e) begin
                    w_cmd.ent_re    = 1'b1;
                    w_cmd.ent_raddr = ENT_AW'(r_j);
                    n_t             = r_i;
                    n_ret           = S_SR_MIR;
                    n_state         = S_E_LAT;
                end else begin
                    n_state = S_SR_DG;
                end
            end
            S_SR_MIR: begin
                if (i_sts.col_ok) begin
                    w_cmd.lat_b = 1'b1;
                    w_cmd.b_sel = B_XI;
                    n_t         = ROWCNT_W'(i_sts.r_col);
                    n_ret       = S_SR_NX;
                    n_state     = S_MUL;
                end else begin
                    n_state = S_SR_NX;
                end
            end
            S_SR_NX: begin
                n_j     = r_j + ENTCNT_W'(1);
                n_state = S_SR_LOOP;
            end
            S_SR_DG: begin
                if (r_end < w_e) begin
                    w_cmd.ent_re    = 1'b1;
                    w_cmd.ent_raddr = ENT_AW'(r_end);
                    n_state         = S_SR_DC;
                end else begin
                    w_cmd.err_set = 1'b1;
                    w_cmd.err_row = r_i[COL_W-1:0];
                    n_state       = S_SR_NROW;
                end
            end
            S_SR_DC: begin
                if (ROWCNT_W'(i_sts.q_col) == r_i) begin
                    w_cmd.lat_a = 1'b1;
                    w_cmd.lat_b = 1'b1;
                    w_cmd.b_sel = B_XI;
                    n_t         = r_i;
                    n_ret       = S_SR_NROW;
                    n_state     = S_MUL;
                end else begin
                    w_cmd.err_set = 1'b1;
                    w_cmd.err_row = r_i[COL_W-1:0];
                    n_state       = S_SR_NROW;
                end
            end
            S_SR_NROW: begin
                if (w_i1 == w_n) begin
                    n_state = S_RES;
                end else begin
                    n_i     = w_i1;
                    n_state = S_SR_P0;
                end
            end
            S_G_P0: begin
                w_cmd.ptr_re    = 1'b1;
                w_cmd.ptr_raddr = ROW_AW'(r_i);
                n_state         = S_G_P1;
            end
            S_G_P1: begin
                n_j = ENTCNT_W'(i_sts.ptr_q);
                if (w_i1 < w_n) begin
                    w_cmd.ptr_re    = 1'b1;
                    w_cmd.ptr_raddr = ROW_AW'(w_i1);
                    n_state         = S_G_P2;
                end else begin
                    n_end   = w_e;
                    n_state = S_G_LOOP;
                end
            end
            S_G_P2: begin
                n_end   = (ENTCNT_W'(i_sts.ptr_q) > w_e) ? w_e : ENTCNT_W'(i_sts.ptr_q);
                n_state = S_G_LOOP;
            end
            S_G_LOOP: begin
                if (r_j < r_end) begin
                    w_cmd.ent_re    = 1'b1;
                    w_cmd.ent_raddr = ENT_AW'(r_j);
                    n_t             = r_i;
                    n_ret           = S_G_NX;
                    n_state         = S_E_LAT;
                end else begin
                    n_state = S_G_NROW;
                end
            end
            S_G_NX: begin
                n_j     = r_j + ENTCNT_W'(1);
                n_state = S_G_LOOP;
            end
            S_G_NROW: begin
                if (w_i1 == w_n) begin
                    n_state = S_RES;
                end else begin
                    n_i     = w_i1;
                    n_state = S_G_P0;
                end
            end
            S_E_LAT: begin
                w_cmd.lat_a   = 1'b1;
                w_cmd.x_re    = 1'b1;
                w_cmd.x_raddr = ROW_AW'(i_sts.q_col);
                n_state       = S_X_LAT;
            end
            S_X_LAT: begin
                w_cmd.lat_b = 1'b1;
                w_cmd.b_sel = B_XCOL;
                n_state     = S_MUL;
            end
            S_LAT_AX: begin
                w_cmd.lat_a = 1'b1;
                w_cmd.lat_b = 1'b1;
                w_cmd.b_sel = B_X;
                n_state     = S_MUL;
            end
            S_MUL: begin
                w_cmd.mul     = 1'b1;
                w_cmd.y_re    = 1'b1;
                w_cmd.y_raddr = ROW_AW'(r_t);
                n_state       = S_PROD;
            end
            S_PROD: begin
                w_cmd.prod = 1'b1;
                n_state    = S_WR;
            end
            S_WR: begin
                w_cmd.y_we    = 1'b1;
                w_cmd.y_waddr = ROW_AW'(r_t);
                n_state       = r_ret;
            end
            S_RES: begin
                if (!r_ovalid || i_m_tready) begin
                    w_cmd.out_load = 1'b1;
                    w_cmd.out_kind = r_rd;
                    n_ovalid       = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_ret    <= S_IDLE;
            r_mode   <= MODE_SYM;
            r_rows   <= ROWCNT_W'(1024);
            r_ents   <= ENTCNT_W'(4096);
            r_i      <= '0;
            r_j      <= '0;
            r_end    <= '0;
            r_t      <= '0;
            r_c      <= '0;
            r_rd     <= RES_STATUS;
            r_ovalid <= 1'b0;
            r_init   <= 1'b1;
        end else begin
            r_state  <= n_state;
            r_ret    <= n_ret;
            r_i      <= n_i;
            r_j      <= n_j;
            r_end    <= n_end;
            r_t      <= n_t;
            r_c      <= n_c;
            r_rd     <= n_rd;
            r_ovalid <= n_ovalid;
            r_init   <= n_init;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_MODE:    r_mode <= i_cfg_data[MODE_W-1:0];
                    CFG_ROWS:    r_rows <= i_cfg_data[ROWCNT_W-1:0];
                    CFG_ENTRIES: r_ents <= i_cfg_data[ENTCNT_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_ovalid;
    assign o_cmd      = w_cmd;

endmodule

>>> rtl/sparse_matrix_vector_product_unit.sv
// ----------------------------------------------------------------------------
// sparse_matrix_vector_product_unit
// Loads a sparse matrix, row pointers and vector x; computes y = A*x in
// diagonal, symmetric-lower or general compressed-row form; reads back y.
// ----------------------------------------------------------------------------
// After reset the unit holds tready low while it clears y. Loads are written
// on acceptance and return nothing; a read of y returns one beat from the result
// register once the output is free. A compute first sweeps y to zero, one row per
// cycle across all MAX_ROWS rows, then walks the stored entries through simple
// dual-port RAMs and one shared multiplier; each product passes the multiply,
// product and write-back states, and symmetric mode also adds the mirrored product
// of each in-range off-diagonal entry. One status beat closes each compute. Values
// are Q16.16, accumulated at 48 bits with saturation and saturated to 32 on read.
module sparse_matrix_vector_product_unit #(
    parameter int MAX_ROWS    = 1024,
    parameter int MAX_ENTRIES = 4096,
    parameter int FRAC_BITS   = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [71:0]                         i_s_tdata,  // slot, value, column, row_start
    input  logic [smvp_pkg::KIND_W-1:0]         i_s_tuser,  // kind
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [55:0]                         o_m_tdata,  // out_value, out_row, diag_error, bad_row
    output logic                                o_m_tuser,  // result_kind
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [smvp_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [smvp_pkg::CFG_DAT_W-1:0]      i_cfg_data
);
    import smvp_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;
    logic w_acc;
    logic w_okind, w_derr;
    logic [VALUE_W-1:0] w_oval;
    logic [COL_W-1:0]   w_orow, w_bad;

    assign w_acc       = i_s_tvalid && o_s_tready;
    assign o_cfg_ready = 1'b1;

    smvp_ctrl #(.MAX_ROWS(MAX_ROWS), .MAX_ENTRIES(MAX_ENTRIES)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_acc       (w_acc),
        .i_kind      (i_s_tuser),
        .i_slot      (i_s_tdata[11:0]),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_m_tready  (i_m_tready),
        .o_s_tready  (o_s_tready),
        .o_m_tvalid  (o_m_tvalid),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    smvp_dp #(.MAX_ROWS(MAX_ROWS), .MAX_ENTRIES(MAX_ENTRIES), .FRAC_BITS(FRAC_BITS)) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_slot        (i_s_tdata[11:0]),
        .i_value       (i_s_tdata[43:12]),
        .i_column      (i_s_tdata[53:44]),
        .i_row_start   (i_s_tdata[65:54]),
        .o_result_kind (w_okind),
        .o_out_value   (w_oval),
        .o_out_row     (w_orow),
        .o_diag_error  (w_derr),
        .o_bad_row     (w_bad)
    );

    assign o_m_tdata = {3'b000, w_bad, w_derr, w_orow, w_oval};
    assign o_m_tuser = w_okind;

    a_y_port : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.y_we && !w_cmd.y_clr) |-> !w_cmd.y_re)
        else $error("y accumulate write collides with a y read");

    a_compute_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_s_tuser == KIND_COMPUTE) |=> !o_s_tready)
        else $error("input taken while compute starts");

    a_status_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser == RES_STATUS) |-> (o_m_tdata[41:0] == '0))
        else $error("status beat carries data");

endmodule

>>> test/sparse_matrix_vector_product_unit_test.sv
// ----------------------------------------------------------------------------
// sparse_matrix_vector_product_unit_test
// Fills the low part of the matrix and x stores, then runs directed computes
// at the size extremes followed by random diagonal, symmetric and general
// phases: well-formed matrices with random content, some broken ones and
// noise. Each accepted beat updates a local model of the unit; every result
// beat is checked field by field against the oldest predicted one.
// ----------------------------------------------------------------------------
module sparse_matrix_vector_product_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import smvp_pkg::*;

    localparam int  ROWS      = 1024;
    localparam int  ENTRIES   = 4096;
    localparam int  FILL      = 64;
    localparam int  FRAC      = 16;
    localparam int  WDOG_MAX  = 300000;
    localparam int  QUIET_MIN = 16;
    localparam longint ACC_HI = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint ACC_LO = -ACC_HI - 1;

    typedef struct {
        bit                    is_cfg;
        bit                    hold;
        logic [KIND_W-1:0]     kind;
        logic [SLOT_W-1:0]     slot;
        logic [VALUE_W-1:0]    value;
        logic [COL_W-1:0]      column;
        logic [PTR_W-1:0]      row_start;
        logic [CFG_IDX_W-1:0]  cidx;
        logic [CFG_DAT_W-1:0]  cdata;
    } beat_t;

    typedef struct {
        logic               kind;
        logic [31:0]        value;
        logic [COL_W-1:0]   row;
        logic               err;
        logic [COL_W-1:0]   bad;
    } result_t;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_vld;
    logic                  o_s_tready;
    logic                  o_m_tvalid;
    logic                  m_rdy;
    logic [55:0]           o_m_tdata;
    logic                  o_m_tuser;
    logic                  c_vld;
    logic                  o_cfg_ready;
    beat_t                 s_beat;
    beat_t                 c_beat;

    beat_t                 plan[$];
    result_t               y_expect[$];

    longint                mat_val[ENTRIES];
    int unsigned           mat_col[ENTRIES];
    int unsigned           row_ptr[ROWS];
    longint                x_vec[ROWS];
    longint                y_acc[ROWS];
    bit                    diag_err;
    int unsigned           first_bad;
    int unsigned           mode_r;
    int unsigned           rows_r;
    int unsigned           ents_r;

    int                    errors;
    int                    acc_cnt;
    int                    want_cnt;
    int                    quiet;
    int                    wdog;
    int                    gap;
    int                    burst;
    int                    rdy_mode;
    int                    rdy_timer;

    sparse_matrix_vector_product_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_vld),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   ({6'b0, s_beat.row_start, s_beat.column, s_beat.value, s_beat.slot}),
        .i_s_tuser   (s_beat.kind),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (m_rdy),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_valid (c_vld),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (c_beat.cidx),
        .i_cfg_data  (c_beat.cdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // ---------------- model ----------------

    function automatic longint sat48(longint v);
        if (v > ACC_HI) return ACC_HI;
        if (v < ACC_LO) return ACC_LO;
        return v;
    endfunction

    function automatic longint qmul(longint a, longint b);
        longint p;
        p = a * b;
        return sat48(p >>> FRAC);
    endfunction

    function automatic void add_y(int unsigned row, longint v);
        if (row < ROWS) y_acc[row] = sat48(y_acc[row] + v);
    endfunction

    function automatic void flag_row(int unsigned row);
        if (!diag_err) begin
            diag_err  = 1'b1;
            first_bad = row & 10'h3FF;
        end
    endfunction

    function automatic void form_product();
        int unsigned n;
        int unsigned e;
        int unsigned d;
        int unsigned stop;
        n = rows_r > ROWS ? ROWS : rows_r;
        e = ents_r > ENTRIES ? ENTRIES : ents_r;
        foreach (y_acc[k]) y_acc[k] = 0;
        diag_err  = 1'b0;
        first_bad = 0;
        if (n == 0) return;
        if (mode_r == MODE_DIAG) begin
            for (int unsigned i = 0; i < n; i++)
                if (i < e) add_y(i, qmul(mat_val[i], x_vec[i]));
        end else if (mode_r == MODE_SYM) begin
            if (e > 0) add_y(0, qmul(mat_val[0], x_vec[0]));
            for (int unsigned i = 1; i < n; i++) begin
                d = row_ptr[i];
                for (int unsigned j = row_ptr[i-1] + 1; j < d; j++) begin
                    if (j >= e) break;
                    add_y(i, qmul(mat_val[j], x_vec[mat_col[j]]));
                    add_y(mat_col[j], qmul(mat_val[j], x_vec[i]));
                end
                if (d < e && mat_col[d] == i) add_y(i, qmul(mat_val[d], x_vec[i]));
                else flag_row(i);
            end
        end else if (mode_r == MODE_GEN) begin
            for (int unsigned i = 0; i < n; i++) begin
                stop = (i + 1 < n) ? row_ptr[i+1] : e;
                if (stop > e) stop = e;
                for (int unsigned j = row_ptr[i]; j < stop; j++)
                    add_y(i, qmul(mat_val[j], x_vec[mat_col[j]]));
            end
        end
    endfunction

    function automatic void apply_beat(beat_t b);
        result_t r;
        longint  y;
        r.err = diag_err;
        case (b.kind)
            KIND_LOAD_ENTRY: begin
                mat_val[b.slot] = longint'($signed(b.value));
                mat_col[b.slot] = b.column;
            end
            KIND_LOAD_PTR: if (b.slot < ROWS) row_ptr[b.slot] = b.row_start;
            KIND_LOAD_X:   if (b.slot < ROWS) x_vec[b.slot] = longint'($signed(b.value));
            KIND_COMPUTE: begin
                form_product();
                r = '{RES_STATUS, 32'd0, 10'd0, diag_err, first_bad[9:0]};
                y_expect.push_back(r);
            end
            KIND_READ_Y: begin
                y = b.slot < ROWS ? y_acc[b.slot] : 0;
                if (y > 64'sh7FFF_FFFF) y = 64'sh7FFF_FFFF;
                if (y < -64'sh8000_0000) y = -64'sh8000_0000;
                r = '{RES_READ, y[31:0], b.slot[9:0], diag_err, first_bad[9:0]};
                y_expect.push_back(r);
            end
            default: ;
        endcase
    endfunction

    function automatic void apply_cfg(beat_t b);
        case (b.cidx)
            CFG_MODE:    mode_r = b.cdata & 13'h3;
            CFG_ROWS:    rows_r = b.cdata & 13'h7FF;
            CFG_ENTRIES: ents_r = b.cdata;
            default: ;
        endcase
    endfunction

    // ---------------- stimulus ----------------

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom;
            3: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
            default: return 32'($signed($urandom_range(0, 20'hFFFFF)) - 20'sh80000);
        endcase
    endfunction

    function automatic void push_item(logic [2:0] k, int slot, logic [31:0] v,
                                      int col, int start);
        beat_t b;
        b = '{default: '0};
        b.kind = k;
        b.slot = slot;
        b.value = v;
        b.column = col;
        b.row_start = start;
        plan.push_back(b);
    endfunction

    function automatic void push_cfg(logic [1:0] idx, int data);
        beat_t b;
        b = '{default: '0};
        b.is_cfg = 1'b1;
        b.cidx = idx;
        b.cdata = data;
        plan.push_back(b);
    endfunction

    function automatic void push_hold();
        beat_t b;
        b = '{default: '0};
        b.hold = 1'b1;
        plan.push_back(b);
    endfunction

    function automatic void push_reads(int n);
        for (int i = 0; i < n; i++) push_item(KIND_READ_Y, i, $urandom, $urandom, $urandom);
        if ($urandom_range(0, 3) == 0)
            push_item(KIND_READ_Y, $urandom_range(ROWS, 4095), $urandom, $urandom, $urandom);
    endfunction

    // one random phase; returns the number of items queued
    function automatic int push_phase();
        int n;
        int j;
        int k;
        int md;
        int base;
        md = $urandom_range(0, 5) == 0 ? MODE_DIAG : ($urandom_range(0, 1) ? MODE_SYM : MODE_GEN);
        n = $urandom_range(1, 12);
        j = 0;
        base = plan.size();
        push_cfg(CFG_MODE, md);
        push_cfg(CFG_ROWS, n);
        if (md == MODE_DIAG) begin
            for (int i = 0; i < n; i++)
                push_item(KIND_LOAD_ENTRY, i, rand_value(), $urandom, $urandom);
            j = n;
        end else if (md == MODE_SYM) begin
            push_item(KIND_LOAD_ENTRY, 0, rand_value(), 0, $urandom);
            push_item(KIND_LOAD_PTR, 0, $urandom, $urandom, 0);
            j = 1;
            for (int i = 1; i < n; i++) begin
                k = $urandom_range(0, 3);
                for (int m = 0; m < k; m++) begin
                    push_item(KIND_LOAD_ENTRY, j, rand_value(),
                              $urandom_range(0, 9) == 0 ? $urandom_range(0, FILL - 1)
                                                        : $urandom_range(0, i - 1), $urandom);
                    j++;
                end
                push_item(KIND_LOAD_ENTRY, j, rand_value(),
                          $urandom_range(0, 11) == 0 ? $urandom_range(0, 1023) : i, $urandom);
                push_item(KIND_LOAD_PTR, i, $urandom, $urandom, j);
                j++;
            end
        end else begin
            for (int i = 0; i < n; i++) begin
                push_item(KIND_LOAD_PTR, i, $urandom, $urandom,
                          $urandom_range(0, 15) == 0 ? $urandom_range(0, j + 2) : j);
                k = $urandom_range(0, 4);
                for (int m = 0; m < k; m++) begin
                    push_item(KIND_LOAD_ENTRY, j, rand_value(),
                              $urandom_range(0, 7) == 0 ? $urandom_range(0, FILL - 1)
                                                        : $urandom_range(0, n - 1), $urandom);
                    j++;
                end
            end
        end
        for (int i = 0; i < n; i++)
            if ($urandom_range(0, 3) != 0) push_item(KIND_LOAD_X, i, rand_value(), $urandom, $urandom);
        if ($urandom_range(0, 4) == 0)
            push_item($urandom_range(0, 1) ? KIND_LOAD_PTR : KIND_LOAD_X,
                      $urandom_range(ROWS, 4095), $urandom, $urandom, $urandom);
        if ($urandom_range(0, 4) == 0)
            push_item(3'($urandom_range(5, 7)), $urandom, $urandom, $urandom, $urandom);
        if (j == 0) j = 1;
        push_cfg(CFG_ENTRIES, $urandom_range(0, 5) == 0 ? $urandom_range(0, j) : j);
        push_item(KIND_COMPUTE, $urandom, $urandom, $urandom, $urandom);
        push_reads(n);
        return plan.size() - base;
    endfunction

    // ---------------- driver ----------------

    always @(negedge i_clk) begin
        beat_t b;
        logic  next_s;
        logic  next_c;
        if (!i_rst_n) begin
            s_vld <= 1'b0;
            c_vld <= 1'b0;
        end else if (!((s_vld || c_vld) && acc_cnt != want_cnt)) begin
            next_s = 1'b0;
            next_c = 1'b0;
            if (gap > 0) begin
                gap--;
            end else if (plan.size() > 0) begin
                b = plan[0];
                if (b.hold || b.is_cfg) begin
                    if (y_expect.size() == 0 && quiet >= QUIET_MIN) begin
                        void'(plan.pop_front());
                        if (b.is_cfg) begin
                            c_beat = b;
                            next_c = 1'b1;
                        end
                    end
                end else begin
                    void'(plan.pop_front());
                    s_beat = b;
                    next_s = 1'b1;
                end
                if (next_s || next_c) begin
                    want_cnt = acc_cnt + 1;
                    if (--burst <= 0) begin
                        burst = $urandom_range(1, 24);
                        gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 6);
                    end
                end
            end
            s_vld <= next_s;
            c_vld <= next_c;
        end
    end

    always @(negedge i_clk) begin
        if (rdy_timer == 0) begin
            rdy_mode  = $urandom_range(0, 3);
            rdy_timer = $urandom_range(20, 150);
        end
        rdy_timer--;
        case (rdy_mode)
            0: m_rdy <= 1'b1;
            1: m_rdy <= $urandom_range(0, 1);
            2: m_rdy <= $urandom_range(0, 3) == 0;
            default: m_rdy <= ($urandom_range(0, 15) != 0) ^ (rdy_timer[3]);
        endcase
    end

    // ---------------- monitor ----------------

    always @(posedge i_clk) begin
        result_t r;
        result_t got;
        bit      moved;
        if (i_rst_n) begin
            moved = 1'b0;
            if (s_vld && o_s_tready) begin
                apply_beat(s_beat);
                acc_cnt++;
                moved = 1'b1;
            end
            if (c_vld && o_cfg_ready) begin
                apply_cfg(c_beat);
                acc_cnt++;
                moved = 1'b1;
            end
            if (o_m_tvalid && m_rdy) begin
                moved = 1'b1;
                got = '{o_m_tuser, o_m_tdata[31:0], o_m_tdata[41:32], o_m_tdata[42],
                        o_m_tdata[52:43]};
                if (y_expect.size() == 0) begin
                    $display("%0t unexpected beat kind %0d value %h row %0d", $realtime,
                             got.kind, got.value, got.row);
                    errors++;
                end else begin
                    r = y_expect.pop_front();
                    if (r != got) begin
                        $display("%0t mismatch: expected kind %0d value %h row %0d err %0d bad %0d",
                                 $realtime, r.kind, r.value, r.row, r.err, r.bad);
                        $display("%0t           actual   kind %0d value %h row %0d err %0d bad %0d",
                                 $realtime, got.kind, got.value, got.row, got.err, got.bad);
                        errors++;
                    end
                end
            end
            quiet = y_expect.size() == 0 ? quiet + 1 : 0;
            wdog = moved ? 0 : wdog + 1;
            if (wdog >= WDOG_MAX) begin
                $display("%0t watchdog expired, %0d results outstanding", $realtime,
                         y_expect.size());
                $display("sparse_matrix_vector_product_unit_test NOT OK");
                $finish;
            end
        end
    end

    // ---------------- sequence ----------------

    initial begin
        int items;
        errors = 0; acc_cnt = 0; want_cnt = 0; quiet = 0; wdog = 0;
        gap = 0; burst = 1; rdy_mode = 0; rdy_timer = 0;
        s_vld = 1'b0; c_vld = 1'b0; m_rdy = 1'b0;
        s_beat = '{default: '0};
        c_beat = '{default: '0};
        foreach (y_acc[k]) y_acc[k] = 0;
        diag_err = 1'b0; first_bad = 0;
        mode_r = MODE_SYM; rows_r = 1024; ents_r = 4096;
        i_rst_n = 1'b0;

        // fill the entries and x words that any compute below can touch
        for (int i = 0; i < FILL; i++) begin
            push_item(KIND_LOAD_ENTRY, i, rand_value(), $urandom, $urandom);
            push_item(KIND_LOAD_X, i, rand_value(), $urandom, $urandom);
        end

        // directed: size extremes, mode three, empty row count, capped sizes
        push_cfg(CFG_MODE, MODE_DIAG);
        push_cfg(CFG_ROWS, 1024);
        push_cfg(CFG_ENTRIES, FILL);
        push_item(KIND_COMPUTE, 0, 0, 0, 0);
        push_item(KIND_READ_Y, 0, 0, 0, 0);
        push_item(KIND_READ_Y, 1023, 0, 0, 0);
        push_item(KIND_READ_Y, 4095, 0, 0, 0);
        push_item(KIND_READ_Y, 1024, 0, 0, 0);
        push_cfg(CFG_ROWS, 2047);
        push_item(KIND_COMPUTE, 0, 0, 0, 0);
        push_item(KIND_READ_Y, 777, 0, 0, 0);
        push_cfg(CFG_ROWS, FILL);
        push_cfg(CFG_ENTRIES, 8191);
        push_item(KIND_COMPUTE, 0, 0, 0, 0);
        push_item(KIND_READ_Y, FILL - 1, 0, 0, 0);
        push_cfg(CFG_ENTRIES, 1);
        push_item(KIND_COMPUTE, 0, 0, 0, 0);
        push_item(KIND_READ_Y, 1, 0, 0, 0);
        push_cfg(CFG_ROWS, 0);
        push_item(KIND_COMPUTE, 0, 0, 0, 0);
        push_item(KIND_READ_Y, 0, 0, 0, 0);
        push_cfg(CFG_MODE, 3);
        push_cfg(CFG_ROWS, 1);
        push_item(KIND_COMPUTE, 0, 0, 0, 0);
        push_item(KIND_READ_Y, 0, 0, 0, 0);
        push_item(3'd7, 5, 0, 0, 0);

        items = 0;
        while (items < 400) begin
            items += push_phase();
            if ($urandom_range(0, 9) == 0) push_hold();
        end
        push_hold();
        push_item(KIND_READ_Y, 0, 0, 0, 0);

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        do @(posedge i_clk);
        while (plan.size() > 0 || s_vld || c_vld || y_expect.size() > 0);
        repeat (40) @(posedge i_clk);

        if (errors == 0 && y_expect.size() == 0) begin
            $display("sparse_matrix_vector_product_unit_test OK");
        end else begin
            $display("sparse_matrix_vector_product_unit_test NOT OK");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/smvp_pkg.sv
rtl/smvp_ram.sv
rtl/smvp_dp.sv
rtl/smvp_ctrl.sv
rtl/sparse_matrix_vector_product_unit.sv
test/sparse_matrix_vector_product_unit_test.sv
